// ===== rtl/mshr_file_alloc_chain_unit_defines.svh =====
// Assertion macros used by the checker file of the MSHR allocation chain unit.
`ifndef MSHR_FILE_ALLOC_CHAIN_UNIT_DEFINES_SVH
`define MSHR_FILE_ALLOC_CHAIN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define MFAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfac assertion failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define MFAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfac assertion failed");

`endif

// ===== rtl/mfac_pkg.sv =====
// Types and constants shared by the MSHR allocation chain unit.
`default_nettype none
package mfac_pkg;

    // Fixed widths of the item fields
    localparam int IDX_FIELD_W = 4;
    localparam int NEXT_W      = 4;

    // Partial search result handed from one cell to the next
    typedef struct packed {
        logic valid;
        logic have_free;
        logic have_active;
        logic tail_hit;
    } mfac_sweep_t;

    // Update broadcast to every cell at the end of a sweep
    typedef struct packed {
        logic                   commit;
        logic                   alloc_ok;
        logic                   free_req;
        logic [IDX_FIELD_W-1:0] free_index;
        logic [NEXT_W-1:0]      next_index;
        logic                   next_none;
    } mfac_commit_t;

    // Control sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } mfac_state_t;

endpackage
`default_nettype wire

// ===== rtl/mfac_if.sv =====
// Request and response channel interfaces of the MSHR allocation chain unit.
`default_nettype none
interface mfac_req_if
    import mfac_pkg::*;
#(
    parameter int ADDR_W = 26
);
    logic                   valid;
    logic                   ready;
    logic                   alloc_req;
    logic [ADDR_W-1:0]      alloc_line_addr;
    logic [NEXT_W-1:0]      alloc_next_index;
    logic                   alloc_next_none;
    logic                   free_req;
    logic [IDX_FIELD_W-1:0] free_index;
    logic [ADDR_W-1:0]      lookup_line_addr;

    modport source (
        output valid, alloc_req, alloc_line_addr, alloc_next_index, alloc_next_none,
               free_req, free_index, lookup_line_addr,
        input  ready
    );
    modport sink (
        input  valid, alloc_req, alloc_line_addr, alloc_next_index, alloc_next_none,
               free_req, free_index, lookup_line_addr,
        output ready
    );
endinterface

interface mfac_rsp_if
    import mfac_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   alloc_ok;
    logic [IDX_FIELD_W-1:0] alloc_index;
    logic                   tail_found;
    logic [IDX_FIELD_W-1:0] tail_index;
    logic                   any_free;
    logic                   any_active;

    modport source (
        output valid, alloc_ok, alloc_index, tail_found, tail_index, any_free, any_active,
        input  ready
    );
    modport sink (
        input  valid, alloc_ok, alloc_index, tail_found, tail_index, any_free, any_active,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/mfac_cell.sv =====
// One MSHR entry plus its stage of the search sweep.
`default_nettype none
module mfac_cell
    import mfac_pkg::*;
#(
    parameter int ADDR_W   = 26,
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
)(
    input  wire                clk,
    input  wire                rst_n,
    input  wire  mfac_sweep_t  sw_in,
    input  wire  [IDX_W-1:0]   free_slot_in,
    input  wire  [IDX_W-1:0]   tail_slot_in,
    output mfac_sweep_t        sw_out,
    output logic [IDX_W-1:0]   free_slot_out,
    output logic [IDX_W-1:0]   tail_slot_out,
    input  wire  [ADDR_W-1:0]  lookup_addr,
    input  wire  mfac_commit_t upd,
    input  wire  [IDX_W-1:0]   alloc_slot,
    input  wire  [ADDR_W-1:0]  alloc_addr
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // Entry storage
    logic              ent_valid_reg, ent_valid_next;
    logic [ADDR_W-1:0] ent_addr_reg;
    logic [NEXT_W-1:0] ent_next_reg;
    logic              ent_none_reg;

    // Sweep stage
    mfac_sweep_t       sw_reg, sw_next;
    logic [IDX_W-1:0]  free_slot_reg, free_slot_next;
    logic [IDX_W-1:0]  tail_slot_reg, tail_slot_next;

    logic alloc_hit;
    logic free_hit;
    logic is_tail;

    assign alloc_hit = upd.commit && upd.alloc_ok && (alloc_slot == MY_IDX);
    assign free_hit  = upd.commit && upd.free_req
                       && ({{(32-IDX_FIELD_W){1'b0}}, upd.free_index} == 32'(CELL_IDX));
    assign is_tail   = ent_valid_reg && ent_none_reg && (ent_addr_reg == lookup_addr);

    // Fold this entry into the partial result coming from the left
    always_comb
    begin
        sw_next.valid       = sw_in.valid;
        sw_next.have_active = sw_in.have_active | ent_valid_reg;
        sw_next.have_free   = sw_in.have_free | ~ent_valid_reg;
        sw_next.tail_hit    = sw_in.tail_hit | is_tail;
        free_slot_next      = sw_in.have_free ? free_slot_in : MY_IDX;
        tail_slot_next      = sw_in.tail_hit ? tail_slot_in : MY_IDX;
    end

    // Allocation wins over a free of the same entry
    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (alloc_hit)
        begin
            ent_valid_next = 1'b1;
        end
        else if (free_hit)
        begin
            ent_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
            sw_reg        <= '0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            sw_reg        <= sw_next;
        end
    end

    // Payload: entry data and slot indices
    always_ff @(posedge clk)
    begin
        free_slot_reg <= free_slot_next;
        tail_slot_reg <= tail_slot_next;
        if (alloc_hit)
        begin
            ent_addr_reg <= alloc_addr;
            ent_next_reg <= upd.next_index;
            ent_none_reg <= upd.next_none;
        end
    end

    assign sw_out        = sw_reg;
    assign free_slot_out = free_slot_reg;
    assign tail_slot_out = tail_slot_reg;

endmodule
`default_nettype wire

// ===== rtl/mshr_file_alloc_chain_unit.sv =====
// Top level of the MSHR allocation chain unit.
// Usage:
//   req carries one tick of work per word: an optional allocation (address and
//   chain link), an optional free by index, and a lookup address. rsp returns one
//   word per request: the slot given, the lowest matching chain tail, and
//   whether any entry was free or active before this tick's updates.
//   Every query sees the entries as they stood before the request; the request's
//   allocation and free land together at the end of its sweep.
// Timing:
//   The entries sit in a row of ENTRY_COUNT cells; a search token walks one cell
//   per cycle. An accepted request is swept through the row, its result is
//   registered, then moved to the output register; req.ready rises again only
//   once the result is in the output register.
//   One request is in flight at a time.
// Reset: all entries become invalid, the sweep empties, no response is pending.
// Stall: a response waits in the output register until rsp.ready; the finished
//   sweep waits behind it and req.ready stays low until it moves out.
`default_nettype none
module mshr_file_alloc_chain_unit
    import mfac_pkg::*;
#(
    parameter int ENTRY_COUNT    = 16,
    parameter int LINE_ADDR_BITS = 26
)(
    input wire          clk,
    input wire          rst_n,
    mfac_req_if.sink    req,
    mfac_rsp_if.source  rsp
);

    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    // Sequencer
    mfac_state_t state_reg, state_next;
    logic        start_reg, start_next;
    logic        accept;
    logic        done;

    // Latched request
    logic                      item_alloc_req_reg;
    logic [LINE_ADDR_BITS-1:0] item_alloc_addr_reg;
    logic [NEXT_W-1:0]         item_next_index_reg;
    logic                      item_next_none_reg;
    logic                      item_free_req_reg;
    logic [IDX_FIELD_W-1:0]    item_free_index_reg;
    logic [LINE_ADDR_BITS-1:0] item_lookup_addr_reg;

    // Chain links
    mfac_sweep_t      sw_chain   [0:ENTRY_COUNT];
    logic [IDX_W-1:0] free_chain [0:ENTRY_COUNT];
    logic [IDX_W-1:0] tail_chain [0:ENTRY_COUNT];
    mfac_commit_t     upd;

    // Finished result, waiting for the output register
    logic                   res_alloc_ok_reg;
    logic [IDX_FIELD_W-1:0] res_alloc_index_reg;
    logic                   res_tail_found_reg;
    logic [IDX_FIELD_W-1:0] res_tail_index_reg;
    logic                   res_any_free_reg;
    logic                   res_any_active_reg;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_alloc_ok_reg;
    logic [IDX_FIELD_W-1:0] out_alloc_index_reg;
    logic                   out_tail_found_reg;
    logic [IDX_FIELD_W-1:0] out_tail_index_reg;
    logic                   out_any_free_reg;
    logic                   out_any_active_reg;

    logic        alloc_ok;
    logic [31:0] free_wide;
    logic [31:0] tail_wide;
    logic        out_free;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign done     = (state_reg == S_SCAN) && sw_chain[ENTRY_COUNT].valid;
    assign out_free = !out_valid_reg || rsp.ready;

    // Inject the token at the head of the row
    assign sw_chain[0]   = '{valid: start_reg, have_free: 1'b0, have_active: 1'b0,
                             tail_hit: 1'b0};
    assign free_chain[0] = '0;
    assign tail_chain[0] = '0;

    // Updates land when the token leaves the last cell
    assign alloc_ok = item_alloc_req_reg && sw_chain[ENTRY_COUNT].have_free;
    always_comb
    begin
        upd.commit     = done;
        upd.alloc_ok   = alloc_ok;
        upd.free_req   = item_free_req_reg;
        upd.free_index = item_free_index_reg;
        upd.next_index = item_next_index_reg;
        upd.next_none  = item_next_none_reg;
    end

    generate
        for (genvar g = 0; g < ENTRY_COUNT; g++)
        begin : g_cell
            mfac_cell #(
                .ADDR_W   (LINE_ADDR_BITS),
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .sw_in         (sw_chain[g]),
                .free_slot_in  (free_chain[g]),
                .tail_slot_in  (tail_chain[g]),
                .sw_out        (sw_chain[g+1]),
                .free_slot_out (free_chain[g+1]),
                .tail_slot_out (tail_chain[g+1]),
                .lookup_addr   (item_lookup_addr_reg),
                .upd           (upd),
                .alloc_slot    (free_chain[ENTRY_COUNT]),
                .alloc_addr    (item_alloc_addr_reg)
            );
        end
    endgenerate

    // Step the sequencer
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    start_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request for the whole sweep
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_alloc_req_reg   <= req.alloc_req;
            item_alloc_addr_reg  <= req.alloc_line_addr;
            item_next_index_reg  <= req.alloc_next_index;
            item_next_none_reg   <= req.alloc_next_none;
            item_free_req_reg    <= req.free_req;
            item_free_index_reg  <= req.free_index;
            item_lookup_addr_reg <= req.lookup_line_addr;
        end
    end

    // Report indices in the 4-bit field, zero when nothing was found
    assign free_wide = 32'(free_chain[ENTRY_COUNT]);
    assign tail_wide = 32'(tail_chain[ENTRY_COUNT]);

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_alloc_ok_reg    <= alloc_ok;
            res_alloc_index_reg <= alloc_ok ? free_wide[IDX_FIELD_W-1:0] : '0;
            res_tail_found_reg  <= sw_chain[ENTRY_COUNT].tail_hit;
            res_tail_index_reg  <= sw_chain[ENTRY_COUNT].tail_hit
                                   ? tail_wide[IDX_FIELD_W-1:0] : '0;
            res_any_free_reg    <= sw_chain[ENTRY_COUNT].have_free;
            res_any_active_reg  <= sw_chain[ENTRY_COUNT].have_active;
        end
        if ((state_reg == S_DRAIN) && out_free)
        begin
            out_alloc_ok_reg    <= res_alloc_ok_reg;
            out_alloc_index_reg <= res_alloc_index_reg;
            out_tail_found_reg  <= res_tail_found_reg;
            out_tail_index_reg  <= res_tail_index_reg;
            out_any_free_reg    <= res_any_free_reg;
            out_any_active_reg  <= res_any_active_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.alloc_ok    = out_alloc_ok_reg;
    assign rsp.alloc_index = out_alloc_index_reg;
    assign rsp.tail_found  = out_tail_found_reg;
    assign rsp.tail_index  = out_tail_index_reg;
    assign rsp.any_free    = out_any_free_reg;
    assign rsp.any_active  = out_any_active_reg;

endmodule
`default_nettype wire

// ===== rtl/mfac_checker.sv =====
// Port-level checks of the MSHR allocation chain unit, bound to the top level.
`default_nettype none
`include "mshr_file_alloc_chain_unit_defines.svh"
module mfac_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_ready,
    input wire       alloc_ok,
    input wire [3:0] alloc_index,
    input wire       tail_found,
    input wire [3:0] tail_index,
    input wire       any_free,
    input wire       any_active
);

    // Hold a stalled word: valid, alloc_ok and both indices stay
    `MFAC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(alloc_ok) && $stable(alloc_index) && $stable(tail_index))

    // Allocate only when a slot was free
    `MFAC_ASSERT_IMPL(a_alloc_needs_free, clk, rst_n, out_valid && alloc_ok, any_free)

    // Find a tail only among active entries
    `MFAC_ASSERT_IMPL(a_tail_needs_active, clk, rst_n, out_valid && tail_found, any_active)

    // Drop indices to zero on a miss
    `MFAC_ASSERT_IMPL(a_idx_zero_on_miss, clk, rst_n, out_valid, (alloc_ok || alloc_index == 4'd0) && (tail_found || tail_index == 4'd0))

endmodule

bind mshr_file_alloc_chain_unit mfac_checker u_mfac_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .alloc_ok    (rsp.alloc_ok),
    .alloc_index (rsp.alloc_index),
    .tail_found  (rsp.tail_found),
    .tail_index  (rsp.tail_index),
    .any_free    (rsp.any_free),
    .any_active  (rsp.any_active)
);
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the MSHR allocation chain unit.
`timescale 1ns / 1ps

module tb;
    import mfac_pkg::*;

    localparam int ADDR_W      = 26;
    localparam int N_ENTRIES   = 16;
    localparam int RANDOM_TICKS = 525;
    localparam int CYCLE_LIMIT = 150000;
    localparam int DRAIN_CYCLES = N_ENTRIES + 24;
    localparam int HOLD_CYCLES = 300;

    // One tick of work for the file
    typedef struct packed {
        logic                   alloc_req;
        logic [ADDR_W-1:0]      alloc_line_addr;
        logic [NEXT_W-1:0]      alloc_next_index;
        logic                   alloc_next_none;
        logic                   free_req;
        logic [IDX_FIELD_W-1:0] free_index;
        logic [ADDR_W-1:0]      lookup_line_addr;
    } tick_word_t;

    // Status returned for one tick
    typedef struct packed {
        logic                   alloc_ok;
        logic [IDX_FIELD_W-1:0] alloc_index;
        logic                   tail_found;
        logic [IDX_FIELD_W-1:0] tail_index;
        logic                   any_free;
        logic                   any_active;
    } file_status_t;

    logic clk = 1'b0;
    logic rst_n;

    mfac_req_if #(.ADDR_W(ADDR_W)) req_ch ();
    mfac_rsp_if                    rsp_ch ();

    mshr_file_alloc_chain_unit #(
        .ENTRY_COUNT    (N_ENTRIES),
        .LINE_ADDR_BITS (ADDR_W)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    tick_word_t   pending_ticks[$];
    file_status_t status_expected[$];

    int cycle_count   = 0;
    int mismatches    = 0;
    int ticks_sent    = 0;
    int statuses_seen = 0;
    int hold_left     = 0;
    int holds_done    = 0;

    // Shadow copy of the entry file
    logic              shadow_valid[N_ENTRIES];
    logic [ADDR_W-1:0] shadow_addr[N_ENTRIES];
    logic [NEXT_W-1:0] shadow_next[N_ENTRIES];
    logic              shadow_none[N_ENTRIES];

    // Search the committed entries, then apply the tick's free and allocation
    function automatic file_status_t tick_file(input tick_word_t w);
        file_status_t s;
        logic         found_free;
        int           free_slot;
        s = '0;
        found_free = 1'b0;
        free_slot = 0;
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (shadow_valid[i]) begin
                s.any_active = 1'b1;
                if (!s.tail_found && shadow_addr[i] == w.lookup_line_addr && shadow_none[i])
                begin
                    s.tail_found = 1'b1;
                    s.tail_index = IDX_FIELD_W'(i);
                end
            end
            else if (!found_free) begin
                found_free = 1'b1;
                free_slot = i;
            end
        end
        s.any_free = found_free;
        s.alloc_ok = w.alloc_req && found_free;
        if (w.free_req && int'(w.free_index) < N_ENTRIES)
            shadow_valid[w.free_index] = 1'b0;
        // allocation lands after the free, so it wins on a shared slot
        if (s.alloc_ok) begin
            s.alloc_index = IDX_FIELD_W'(free_slot);
            shadow_valid[free_slot] = 1'b1;
            shadow_addr[free_slot] = w.alloc_line_addr;
            shadow_next[free_slot] = w.alloc_next_index;
            shadow_none[free_slot] = w.alloc_next_none;
        end
        return s;
    endfunction

    task automatic add_tick(input logic a_req, input logic [ADDR_W-1:0] a_addr,
                            input logic [NEXT_W-1:0] a_next, input logic a_none,
                            input logic f_req, input logic [IDX_FIELD_W-1:0] f_idx,
                            input logic [ADDR_W-1:0] l_addr);
        tick_word_t w;
        w.alloc_req = a_req;
        w.alloc_line_addr = a_addr;
        w.alloc_next_index = a_next;
        w.alloc_next_none = a_none;
        w.free_req = f_req;
        w.free_index = f_idx;
        w.lookup_line_addr = l_addr;
        pending_ticks.push_back(w);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d status %0d: %s", cycle_count, statuses_seen, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Count cycles and stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Hold off the status side for long stretches so the file backs up
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        else if ((holds_done == 0 && statuses_seen == 100) ||
                 (holds_done == 1 && statuses_seen == 400)) begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Driver: offer tick words, hold each one until it is taken
    always @(posedge clk or negedge rst_n) begin
        logic       offering;
        logic       may_idle;
        tick_word_t w;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end
        else begin
            offering = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                status_expected.push_back(tick_file(pending_ticks.pop_front()));
                ticks_sent <= ticks_sent + 1;
                offering = 1'b0;
            end
            may_idle = !(ticks_sent >= 220 && ticks_sent < 320) && hold_left == 0;
            if (!offering) begin
                if (pending_ticks.size() > 0 && !(may_idle && $urandom_range(99) < 24)) begin
                    w = pending_ticks[0];
                    req_ch.valid <= 1'b1;
                    req_ch.alloc_req <= w.alloc_req;
                    req_ch.alloc_line_addr <= w.alloc_line_addr;
                    req_ch.alloc_next_index <= w.alloc_next_index;
                    req_ch.alloc_next_none <= w.alloc_next_none;
                    req_ch.free_req <= w.free_req;
                    req_ch.free_index <= w.free_index;
                    req_ch.lookup_line_addr <= w.lookup_line_addr;
                end
                else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take status words and check them against the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        file_status_t want;
        logic         may_idle;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (status_expected.size() == 0) begin
                    report_mismatch("status word with nothing expected");
                end
                else begin
                    want = status_expected.pop_front();
                    compare_field("alloc_ok", int'(rsp_ch.alloc_ok), int'(want.alloc_ok));
                    compare_field("alloc_index", int'(rsp_ch.alloc_index),
                                  int'(want.alloc_index));
                    compare_field("tail_found", int'(rsp_ch.tail_found),
                                  int'(want.tail_found));
                    compare_field("tail_index", int'(rsp_ch.tail_index),
                                  int'(want.tail_index));
                    compare_field("any_free", int'(rsp_ch.any_free), int'(want.any_free));
                    compare_field("any_active", int'(rsp_ch.any_active),
                                  int'(want.any_active));
                end
                statuses_seen <= statuses_seen + 1;
            end
            may_idle = !(statuses_seen >= 220 && statuses_seen < 320);
            rsp_ch.ready <= (hold_left == 0) && !(may_idle && $urandom_range(99) < 24);
        end
    end

    initial begin
        logic [ADDR_W-1:0] addr_pool[6];
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] l_addr;
        int                alloc_pct;

        // Start every input at a known value
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.alloc_req = 1'b0;
        req_ch.alloc_line_addr = '0;
        req_ch.alloc_next_index = '0;
        req_ch.alloc_next_none = 1'b0;
        req_ch.free_req = 1'b0;
        req_ch.free_index = '0;
        req_ch.lookup_line_addr = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < N_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_addr[i] = '0;
            shadow_next[i] = '0;
            shadow_none[i] = 1'b0;
        end

        // Empty file: lookup misses, free of an invalid entry does nothing
        add_tick(1'b0, '0, '0, 1'b0, 1'b1, 4'd0, '0);
        // Slot 0 takes the lowest address as a tail
        add_tick(1'b1, '0, '0, 1'b1, 1'b0, 4'd0, '1);
        // Fill the rest, alternating the extreme and mixed addresses
        for (int i = 1; i < N_ENTRIES; i++)
            add_tick(1'b1, i[0] ? {ADDR_W{1'b1}} : ADDR_W'(i * 26'h0155555),
                     NEXT_W'(i), i[1], 1'b0, 4'd0, i[0] ? '0 : '1);
        // Full file: allocation is refused
        add_tick(1'b1, 26'h2AAAAAA, 4'hF, 1'b1, 1'b0, 4'd0, '1);
        // A slot freed this tick is not reused until the next one
        add_tick(1'b1, 26'h1555555, 4'hA, 1'b1, 1'b1, 4'd5, '0);
        add_tick(1'b1, 26'h1555555, 4'h5, 1'b1, 1'b0, 4'd0, 26'h1555555);
        // Free an entry, then free it again while allocating into it
        add_tick(1'b0, '0, '0, 1'b0, 1'b1, 4'd7, 26'h1555555);
        add_tick(1'b1, 26'h3FFFFFF, 4'h0, 1'b1, 1'b1, 4'd7, '1);
        // A freed entry keeps its data but no longer matches
        add_tick(1'b0, '0, '0, 1'b0, 1'b1, 4'd0, '0);
        add_tick(1'b0, '0, '0, 1'b0, 1'b0, 4'hF, '0);

        // Random part: a small pool of addresses so chains and tails collide
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < 6; i++)
            addr_pool[i] = ADDR_W'($urandom);
        for (int k = 0; k < RANDOM_TICKS; k++) begin
            // cycle through filling, balanced and draining phases
            case ((k / 75) % 3)
                0:       alloc_pct = 85;
                1:       alloc_pct = 50;
                default: alloc_pct = 15;
            endcase
            a_addr = ($urandom_range(99) < 80) ? addr_pool[$urandom_range(5)]
                                              : ADDR_W'($urandom);
            l_addr = ($urandom_range(99) < 80) ? addr_pool[$urandom_range(5)]
                                              : ADDR_W'($urandom);
            add_tick($urandom_range(99) < alloc_pct, a_addr, NEXT_W'($urandom),
                     $urandom_range(99) < 70, $urandom_range(99) < (100 - alloc_pct),
                     IDX_FIELD_W'($urandom), l_addr);
        end

        // Hold reset, then release it on a clock edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to go in and every status to come back
        while (pending_ticks.size() != 0 || status_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && status_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mfac_pkg.sv
rtl/mfac_if.sv
rtl/mfac_cell.sv
rtl/mshr_file_alloc_chain_unit.sv
rtl/mfac_checker.sv
dv/tb.sv
